FILE: hw/rtl/cdeq_pkg.sv
// Package for the circular double-ended queue: depth, index widths,
// opcode and status codes, and index wrap helpers.
// No dependencies.
package cdeq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  function automatic idx_t idx_inc(input idx_t i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

FILE: hw/rtl/cdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module cdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/circular_double_ended_queue.sv
// Circular double-ended queue of signed 32-bit words, top level.
// Depends on cdeq_pkg and cdeq_ram.
//
// Input channel (s_axis): tuser carries the opcode (push front, push rear,
// pop front, pop rear, list), tdata the word to push.
// Output channel (m_axis): tuser carries the status (ok, full, empty), tdata
// the popped or listed word (zero otherwise), tlast marks the final item
// caused by one input item.
// One input item is taken at a time. A push, or any operation on an empty
// queue, answers in the output register in the cycle after acceptance; the
// next item can be taken once that register is free. A pop reads the entry
// RAM word into the read register, then into the output register once it
// is free. A list of N entries streams N items, one per cycle after the
// first read while the receiver takes them; the RAM read port sets this
// pace; tready stays low until the last is out. Opcodes 5 to 7 give no item.
// Reset leaves the queue empty with both indices at zero; the RAM is not
// cleared, since entries are read only after they were written.
// When the receiver stalls, the output register holds its item and the
// pending RAM read data is kept until the register frees up.
module circular_double_ended_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cdeq_pkg::WORD_W-1:0]   s_axis_tdata,  // [31:0] push_value
  input  logic [cdeq_pkg::OP_W-1:0]     s_axis_tuser,  // [2:0] opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cdeq_pkg::WORD_W-1:0]   m_axis_tdata,  // [31:0] word_out
  output logic [cdeq_pkg::STATUS_W-1:0] m_axis_tuser,  // [1:0] status
  output logic                          m_axis_tlast   // last_of_run
);

  import cdeq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e  state_q, state_d;
  idx_t    head_q, head_d;
  idx_t    tail_q, tail_d;
  logic    empty_q, empty_d;
  idx_t    walk_q, walk_d;     // next entry to read during a list
  cnt_t    remain_q, remain_d; // words left, including the one in flight
  logic    m_valid_q, m_valid_d;
  status_e m_status_q, m_status_d;
  word_t   m_word_q, m_word_d;
  logic    m_last_q, m_last_d;

  logic    ram_we, ram_re;
  idx_t    ram_waddr, ram_raddr;
  word_t   ram_rdata;

  logic    out_free, accept, full;
  cnt_t    count;
  opcode_e opcode;

  cdeq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = !empty_q && (idx_inc(tail_q) == head_q);
  assign opcode        = opcode_e'(s_axis_tuser);
  assign count         = (tail_q >= head_q)
                         ? CNT_W'(tail_q) - CNT_W'(head_q) + 1'b1
                         : CNT_W'(tail_q) + CNT_W'(QUEUE_DEPTH) - CNT_W'(head_q) + 1'b1;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    walk_d     = walk_q;
    remain_d   = remain_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_word_d   = m_word_q;
    m_last_d   = m_last_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              m_valid_d = 1'b1;
              m_word_d  = '0;
              m_last_d  = 1'b1;
              if (full) begin
                m_status_d = ST_FULL;
              end else begin
                m_status_d = ST_OK;
                ram_we     = 1'b1;
                empty_d    = 1'b0;
                if (empty_q) begin
                  head_d    = '0;
                  tail_d    = '0;
                  ram_waddr = '0;
                end else if (opcode == OP_PUSH_FRONT) begin
                  head_d    = idx_dec(head_q);
                  ram_waddr = idx_dec(head_q);
                end else begin
                  tail_d    = idx_inc(tail_q);
                  ram_waddr = idx_inc(tail_q);
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (empty_q) begin
                m_valid_d  = 1'b1;
                m_status_d = ST_EMPTY;
                m_word_d   = '0;
                m_last_d   = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = (opcode == OP_POP_FRONT) ? head_q : tail_q;
                remain_d  = CNT_W'(1);
                state_d   = S_READ;
                if (head_q == tail_q) begin
                  empty_d = 1'b1;
                  head_d  = '0;
                  tail_d  = '0;
                end else if (opcode == OP_POP_FRONT) begin
                  head_d = idx_inc(head_q);
                end else begin
                  tail_d = idx_dec(tail_q);
                end
              end
            end
            OP_LIST: begin
              if (empty_q) begin
                m_valid_d  = 1'b1;
                m_status_d = ST_EMPTY;
                m_word_d   = '0;
                m_last_d   = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                walk_d    = idx_inc(head_q);
                remain_d  = count;
                state_d   = S_READ;
              end
            end
            default: begin
              // undefined opcodes give no item
            end
          endcase
        end
      end
      S_READ: begin
        // read data is valid here and holds until it is moved out
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = ST_OK;
          m_word_d   = ram_rdata;
          m_last_d   = (remain_q == CNT_W'(1));
          if (remain_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = walk_q;
            walk_d    = idx_inc(walk_q);
            remain_d  = remain_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      empty_q   <= 1'b1;
      walk_q    <= '0;
      remain_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      empty_q   <= empty_d;
      walk_q    <= walk_d;
      remain_q  <= remain_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_word_q   <= m_word_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_word_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: tb/circular_double_ended_queue_tb.sv
`timescale 1ns / 1ps
// Testbench for circular_double_ended_queue: sends push, pop, list and reserved-opcode items,
// predicts every result from its own deque model and checks the output stream.
// Depends on cdeq_pkg and the queue RTL.
module circular_double_ended_queue_tb;
  import cdeq_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;
  localparam int PHASE_ITEMS  = 45;

  typedef struct packed {
    status_e status;
    word_t   word;
    logic    last;
  } queue_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [WORD_W-1:0]   s_axis_tdata;
  logic [OP_W-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [WORD_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  int src_idle_pct;
  int sink_stall_pct;
  int fail_count;
  int items_sent;
  int results_seen;
  int full_hits;
  int empty_hits;
  int list_runs;
  int quiet_cycles;

  // deque model state
  queue_result_t expected_results[$];
  word_t         model_mem[QUEUE_DEPTH];
  int            front_idx;
  int            rear_idx;
  bit            model_empty;

  circular_double_ended_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int wrap_next(input int i);
    return (i + 1) % QUEUE_DEPTH;
  endfunction

  function automatic int wrap_prev(input int i);
    return (i + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
  endfunction

  function automatic void add_result(input status_e st, input word_t w, input logic last);
    expected_results.push_back('{status: st, word: w, last: last});
  endfunction

  // Updates the deque model for one accepted item and queues its results.
  function automatic void predict_queue_op(input logic [OP_W-1:0] op, input word_t value);
    int    count;
    int    idx;
    word_t popped;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (!model_empty && wrap_next(rear_idx) == front_idx) begin
          full_hits++;
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          if (model_empty) begin
            // first entry always lands at slot 0
            front_idx   = 0;
            rear_idx    = 0;
            model_empty = 1'b0;
            model_mem[0] = value;
          end else if (op == OP_PUSH_FRONT) begin
            front_idx = wrap_prev(front_idx);
            model_mem[front_idx] = value;
          end else begin
            rear_idx = wrap_next(rear_idx);
            model_mem[rear_idx] = value;
          end
          add_result(ST_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (model_empty) begin
          empty_hits++;
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          popped = model_mem[(op == OP_POP_FRONT) ? front_idx : rear_idx];
          if (front_idx == rear_idx) begin
            model_empty = 1'b1;
            front_idx   = 0;
            rear_idx    = 0;
          end else if (op == OP_POP_FRONT) begin
            front_idx = wrap_next(front_idx);
          end else begin
            rear_idx = wrap_prev(rear_idx);
          end
          add_result(ST_OK, popped, 1'b1);
        end
      end
      OP_LIST: begin
        if (model_empty) begin
          empty_hits++;
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          list_runs++;
          count = ((rear_idx + QUEUE_DEPTH - front_idx) % QUEUE_DEPTH) + 1;
          idx   = front_idx;
          for (int i = 0; i < count; i++) begin
            add_result(ST_OK, model_mem[idx], (i + 1 == count));
            idx = wrap_next(idx);
          end
        end
      end
      default: ;  // reserved opcodes: no result
    endcase
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Sends one item; valid stays high afterwards unless the next call idles.
  task automatic send_item(input logic [OP_W-1:0] op, input word_t value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_queue_op(op, value);
    if (op <= OP_LIST) items_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_item(OP_POP_FRONT, $urandom);
    send_item(OP_POP_REAR, $urandom);
    send_item(OP_LIST, $urandom);
    for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++)
      send_item(op[OP_W-1:0], $urandom);
    // push onto empty, then pop of the last entry from the other end
    send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_item(OP_POP_REAR, $urandom);
    send_item(OP_PUSH_REAR, 32'h8000_0000);
    send_item(OP_POP_FRONT, $urandom);
    wait_for_results();
  endtask

  task automatic test_extreme_words();
    send_item(OP_PUSH_REAR, 32'h8000_0000);
    send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_item(OP_PUSH_REAR, 32'h0000_0000);
    send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(OP_PUSH_REAR, 32'hAAAA_AAAA);
    send_item(OP_PUSH_FRONT, 32'h5555_5555);
    send_item(OP_LIST, 32'hFFFF_FFFF);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_REAR, '0);
    send_item(OP_W'(OP_RESERVED_LO + 1), 32'hFFFF_FFFF);
    send_item(OP_LIST, '0);
    wait_for_results();
  endtask

  task automatic run_episode();
    int              kind;
    int              len;
    logic [OP_W-1:0] op;
    kind = $urandom_range(9);
    if (kind < 3) begin
      // fill past capacity so the full case shows up, then dump contents
      len = $urandom_range(QUEUE_DEPTH + 4, QUEUE_DEPTH + 1);
      repeat (len)
        send_item($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR, random_word());
      send_item(OP_LIST, $urandom);
    end else if (kind < 6) begin
      len = $urandom_range(QUEUE_DEPTH + 2, 4);
      repeat (len) begin
        if ($urandom_range(5) == 0) op = OP_LIST;
        else op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
        send_item(op, $urandom);
      end
    end else if (kind < 9) begin
      len = $urandom_range(12, 4);
      repeat (len) send_item(OP_W'($urandom_range(OP_LIST)), random_word());
    end else begin
      repeat ($urandom_range(3, 1))
        send_item(OP_W'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO)), $urandom);
      send_item(OP_W'($urandom_range(OP_LIST)), random_word());
    end
  endtask

  task automatic test_random_traffic();
    int start_count;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) run_episode();
      wait_for_results();
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: status %0d word %h last %b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata !== want.word ||
            m_axis_tlast !== want.last) begin
          fail_count++;
          $display("%0t: mismatch: want st %0d word %h last %b, got st %0d word %h last %b",
                   $time, want.status, want.word, want.last,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // counts cycles in which neither side moves an item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    full_hits      = 0;
    empty_hits     = 0;
    list_runs      = 0;
    model_empty    = 1'b1;
    front_idx      = 0;
    rear_idx       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_extreme_words();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d queue operations giving %0d results: %0d pushes on a full queue,",
             items_sent, results_seen, full_hits);
    $display("%0d pops or lists on an empty queue, %0d non-empty lists, reserved opcodes.",
             empty_hits, list_runs);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
